FILE: sv/td_lambda_linear_value_update_assert.svh
// Assertion macros shared by the TD(lambda) value update block.
`ifndef TD_LAMBDA_LINEAR_VALUE_UPDATE_ASSERT_SVH
`define TD_LAMBDA_LINEAR_VALUE_UPDATE_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled during rst.
`define TDL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("td_lambda check failed");
// Next-cycle implication, sampled on clk and disabled during rst.
`define TDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("td_lambda check failed");
`else
`define TDL_ASSERT_NOW(lbl, ante, cons)
`define TDL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/tdl_pkg.sv
// Shared types, constants and helper functions of the TD(lambda) value update block.
`timescale 1ns / 1ps
`default_nettype none
package tdl_pkg;

  localparam int FEAT_W      = 12;
  localparam int MAX_TILINGS = 8;
  localparam int TILE_W      = 3;
  localparam int VAL_W       = 32;
  localparam int TRACE_W     = 24;
  localparam int STEP_W      = 16;
  localparam int RATE_W      = 17;
  localparam int ACC_W       = 35;
  localparam int WIDE_W      = 42;
  localparam int LIMIT_W     = 17;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 17;

  // Operand and product widths of the shared multiply unit.
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 25;
  localparam int MUL_C_W = 34;
  localparam int MUL_D_W = 24;
  localparam int PS_W    = 57;
  localparam int PU_W    = 58;

  localparam int DEF_WEIGHT_COUNT = 4096;
  localparam int DEF_NUM_TILINGS  = 8;

  localparam logic [TRACE_W-1:0] TRACE_MAX = '1;
  localparam logic [TRACE_W:0]   TRACE_ONE = 25'd65536;

  localparam logic [STEP_W-1:0] STEP_RESET     = '0;
  localparam logic [RATE_W-1:0] DISCOUNT_RESET = 17'd65536;
  localparam logic [RATE_W-1:0] DECAY_RESET    = '0;

  // Operation codes; any other code behaves as a query.
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] REG_STEP_SIZE     = 2'd0;
  localparam logic [CFG_AW-1:0] REG_DISCOUNT_RATE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_TRACE_DECAY   = 2'd2;

  typedef enum logic [1:0] {
    MUL_DISC  = 2'd0,
    MUL_GAIN  = 2'd1,
    MUL_SWEEP = 2'd2
  } mul_sel_t;

  typedef logic [MAX_TILINGS-1:0][FEAT_W-1:0] idx_vec_t;

  typedef struct packed {
    logic              latch;
    logic              gather_rd;
    logic              gather_acc;
    logic              is_update;
    logic              zero_wr;
    logic              zero_weights;
    logic              sweep_rd;
    logic              load_td;
    logic              load_gain;
    mul_sel_t          mul_sel;
    logic [TILE_W-1:0] tsel;
  } ctrl_t;

  // Saturates a wide signed value to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-VAL_W:0] top;
    top = v[WIDE_W-1:VAL_W-1];
    if (top == '0 || top == '1) begin
      return v[VAL_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      return {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/tdl_alu.sv
// Shared multiply unit: one signed and one unsigned product, both registered.
`timescale 1ns / 1ps
`default_nettype none
module tdl_alu
  import tdl_pkg::*;
(
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  op_a,
  input  logic signed [MUL_B_W-1:0]  op_b,
  input  logic        [MUL_C_W-1:0]  op_c,
  input  logic        [MUL_D_W-1:0]  op_d,
  output logic signed [PS_W-1:0]     prod_s,
  output logic        [PU_W-1:0]     prod_u
);

  // Both products fit their result widths exactly.
  always_ff @(posedge clk) begin
    prod_s <= op_a * op_b;
    prod_u <= op_c * op_d;
  end

endmodule
`default_nettype wire

FILE: sv/tdl_dpath.sv
// Datapath: weight and trace memories, sum accumulator, TD and gain registers, sweep pipeline.
`timescale 1ns / 1ps
`default_nettype none
module tdl_dpath
  import tdl_pkg::*;
#(
  parameter int WEIGHT_COUNT = DEF_WEIGHT_COUNT,
  localparam int AW = $clog2(WEIGHT_COUNT)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_t                     ctrl,
  input  logic [AW-1:0]             cnt,
  input  idx_vec_t                  feature_index,
  input  logic signed [VAL_W-1:0]   reward,
  input  logic signed [VAL_W-1:0]   next_value,
  input  logic [STEP_W-1:0]         step_size,
  input  logic [RATE_W-1:0]         discount_rate,
  input  logic [RATE_W-1:0]         trace_decay,
  output logic signed [VAL_W-1:0]   value_sum,
  output logic signed [VAL_W-1:0]   td_error
);

  localparam logic [LIMIT_W-1:0] LIMIT = LIMIT_W'(WEIGHT_COUNT);

  logic signed [VAL_W-1:0]   wmem [WEIGHT_COUNT];
  logic        [TRACE_W-1:0] tmem [WEIGHT_COUNT];

  idx_vec_t                  idx_q;
  logic signed [VAL_W-1:0]   reward_q;
  logic signed [VAL_W-1:0]   nv_q;
  logic signed [ACC_W-1:0]   acc;
  logic signed [VAL_W-1:0]   td_q;
  logic signed [VAL_W-1:0]   gain_q;
  logic        [MUL_C_W-1:0] mul_q;

  logic [FEAT_W-1:0]         sel_idx;
  logic                      sel_ok;
  logic [AW-1:0]             sel_addr;
  logic [AW-1:0]             rd_addr;
  logic signed [VAL_W-1:0]   w_rd;
  logic [TRACE_W-1:0]        t_rd;

  logic                      s1_vld;
  logic                      s2_vld;
  logic [AW-1:0]             s1_addr;
  logic [AW-1:0]             s2_addr;
  logic signed [VAL_W-1:0]   w2;

  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic [MUL_C_W-1:0]        op_c;
  logic [MUL_D_W-1:0]        op_d;
  logic signed [PS_W-1:0]    prod_s;
  logic [PU_W-1:0]           prod_u;

  logic signed [PS_W-1:0]    ps_rnd;
  logic signed [PS_W-17:0]   ps_sh;
  logic signed [WIDE_W-1:0]  td_wide;
  logic signed [WIDE_W-1:0]  w_sum;
  logic signed [VAL_W-1:0]   new_w;
  logic [PU_W:0]             pu_rnd;
  logic [PU_W-32:0]          t_dec;
  logic [TRACE_W-1:0]        new_t;
  logic [TRACE_W:0]          t_inc;
  logic [TRACE_W-1:0]        t_inc_sat;

  logic                      w_we;
  logic [AW-1:0]             w_waddr;
  logic signed [VAL_W-1:0]   w_wdata;
  logic                      t_we;
  logic [AW-1:0]             t_waddr;
  logic [TRACE_W-1:0]        t_wdata;

  // Active index of the tiling under work; indexes past the table are skipped.
  assign sel_idx  = idx_q[ctrl.tsel];
  assign sel_ok   = {{(LIMIT_W-FEAT_W){1'b0}}, sel_idx} < LIMIT;
  assign sel_addr = AW'(sel_idx);
  assign rd_addr  = ctrl.gather_rd ? sel_addr : cnt;

  // Round to nearest (ties up) and drop 16 fraction bits of the signed product.
  assign ps_rnd = prod_s + PS_W'(32768);
  assign ps_sh  = ps_rnd[PS_W-1:16];

  assign value_sum = sat32(WIDE_W'(acc));
  assign td_error  = td_q;

  assign td_wide = WIDE_W'(reward_q) + WIDE_W'(ps_sh) - WIDE_W'(value_sum);
  assign w_sum   = WIDE_W'(w2) + WIDE_W'(ps_sh);
  assign new_w   = sat32(w_sum);

  // Trace decay rounds off 32 fraction bits of trace times (gamma * lambda).
  assign pu_rnd = {1'b0, prod_u} + (PU_W+1)'(64'h8000_0000);
  assign t_dec  = pu_rnd[PU_W:32];
  assign new_t  = (t_dec > (PU_W-31)'(TRACE_MAX)) ? TRACE_MAX : t_dec[TRACE_W-1:0];

  assign t_inc     = {1'b0, t_rd} + TRACE_ONE;
  assign t_inc_sat = t_inc[TRACE_W] ? TRACE_MAX : t_inc[TRACE_W-1:0];

  always_comb begin
    case (ctrl.mul_sel)
      MUL_DISC: begin
        op_a = nv_q;
        op_b = {{(MUL_B_W-RATE_W){1'b0}}, discount_rate};
        op_c = {{(MUL_C_W-RATE_W){1'b0}}, discount_rate};
        op_d = {{(MUL_D_W-RATE_W){1'b0}}, trace_decay};
      end
      MUL_GAIN: begin
        op_a = td_q;
        op_b = {{(MUL_B_W-STEP_W){1'b0}}, step_size};
        op_c = mul_q;
        op_d = t_rd;
      end
      default: begin
        op_a = gain_q;
        op_b = {1'b0, t_rd};
        op_c = mul_q;
        op_d = t_rd;
      end
    endcase
  end

  tdl_alu u_alu (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .op_c   (op_c),
    .op_d   (op_d),
    .prod_s (prod_s),
    .prod_u (prod_u)
  );

  // The sweep write back takes priority; it never overlaps the other writers.
  always_comb begin
    w_we    = s2_vld || (ctrl.zero_wr && ctrl.zero_weights);
    w_waddr = s2_vld ? s2_addr : cnt;
    w_wdata = s2_vld ? new_w : '0;
    t_we    = s2_vld || ctrl.zero_wr || (ctrl.gather_acc && ctrl.is_update && sel_ok);
    if (s2_vld) begin
      t_waddr = s2_addr;
      t_wdata = new_t;
    end else if (ctrl.gather_acc) begin
      t_waddr = sel_addr;
      t_wdata = t_inc_sat;
    end else begin
      t_waddr = cnt;
      t_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wdata;
    end
    w_rd <= wmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
    t_rd <= tmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= ctrl.sweep_rd;
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= cnt;
    s2_addr <= s1_addr;
    w2      <= w_rd;
    if (ctrl.latch) begin
      idx_q    <= feature_index;
      reward_q <= reward;
      nv_q     <= next_value;
      acc      <= '0;
      td_q     <= '0;
    end else begin
      if (ctrl.gather_acc && sel_ok) begin
        acc <= acc + ACC_W'(w_rd);
      end
      if (ctrl.load_td) begin
        td_q <= sat32(td_wide);
      end
    end
    if (ctrl.load_td) begin
      mul_q <= prod_u[MUL_C_W-1:0];
    end
    if (ctrl.load_gain) begin
      gain_q <= ps_rnd[VAL_W+15:16];
    end
  end

endmodule
`default_nettype wire

FILE: sv/tdl_seq.sv
// Sequencer: steps the datapath through gather, TD math, sweeps and memory clears.
`timescale 1ns / 1ps
`default_nettype none
module tdl_seq
  import tdl_pkg::*;
#(
  parameter int WEIGHT_COUNT = DEF_WEIGHT_COUNT,
  parameter int NUM_TILINGS  = DEF_NUM_TILINGS,
  localparam int AW = $clog2(WEIGHT_COUNT)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    opcode,
  output logic          busy,
  output logic          done,
  output ctrl_t         ctrl,
  output logic [AW-1:0] cnt
);

  localparam logic [AW-1:0]     CNT_LAST  = AW'(WEIGHT_COUNT - 1);
  localparam logic [TILE_W-1:0] TILE_LAST = TILE_W'(NUM_TILINGS - 1);

  typedef enum logic [12:0] {
    S_INIT   = 13'h0001,
    S_IDLE   = 13'h0002,
    S_RD     = 13'h0004,
    S_ACC    = 13'h0008,
    S_DISC   = 13'h0010,
    S_TD     = 13'h0020,
    S_GAIN   = 13'h0040,
    S_GAINR  = 13'h0080,
    S_SWEEP  = 13'h0100,
    S_DRAIN1 = 13'h0200,
    S_DRAIN2 = 13'h0400,
    S_CLEAR  = 13'h0800,
    S_FINISH = 13'h1000
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [1:0]        op_q;
  logic [TILE_W-1:0] tcnt;
  logic [TILE_W-1:0] tcnt_next;
  logic [AW-1:0]     cnt_next;
  logic              cnt_last;

  assign cnt_last = (cnt == CNT_LAST);
  assign busy     = (state != S_IDLE);
  assign done     = (state == S_FINISH);

  always_comb begin
    state_next     = state;
    tcnt_next      = tcnt;
    cnt_next       = cnt;
    ctrl           = '0;
    ctrl.mul_sel   = MUL_SWEEP;
    ctrl.tsel      = tcnt;
    ctrl.is_update = (op_q == OP_UPDATE);
    case (state)
      S_INIT: begin
        ctrl.zero_wr      = 1'b1;
        ctrl.zero_weights = 1'b1;
        cnt_next          = cnt_last ? '0 : cnt + AW'(1);
        if (cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          ctrl.latch = 1'b1;
          tcnt_next  = '0;
          state_next = S_RD;
        end
      end
      S_RD: begin
        ctrl.gather_rd = 1'b1;
        state_next     = S_ACC;
      end
      S_ACC: begin
        ctrl.gather_acc = 1'b1;
        if (tcnt == TILE_LAST) begin
          if (op_q == OP_UPDATE) begin
            state_next = S_DISC;
          end else if (op_q == OP_CLEAR) begin
            state_next = S_CLEAR;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          tcnt_next  = tcnt + TILE_W'(1);
          state_next = S_RD;
        end
      end
      S_DISC: begin
        ctrl.mul_sel = MUL_DISC;
        state_next   = S_TD;
      end
      S_TD: begin
        ctrl.load_td = 1'b1;
        state_next   = S_GAIN;
      end
      S_GAIN: begin
        ctrl.mul_sel = MUL_GAIN;
        state_next   = S_GAINR;
      end
      S_GAINR: begin
        ctrl.load_gain = 1'b1;
        state_next     = S_SWEEP;
      end
      S_SWEEP: begin
        ctrl.sweep_rd = 1'b1;
        cnt_next      = cnt_last ? '0 : cnt + AW'(1);
        if (cnt_last) begin
          state_next = S_DRAIN1;
        end
      end
      S_DRAIN1: begin
        state_next = S_DRAIN2;
      end
      S_DRAIN2: begin
        state_next = S_FINISH;
      end
      S_CLEAR: begin
        ctrl.zero_wr = 1'b1;
        cnt_next     = cnt_last ? '0 : cnt + AW'(1);
        if (cnt_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      tcnt  <= '0;
      cnt   <= '0;
      op_q  <= '0;
    end else begin
      state <= state_next;
      tcnt  <= tcnt_next;
      cnt   <= cnt_next;
      if (ctrl.latch) begin
        op_q <= opcode;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/td_lambda_linear_value_update.sv
// Top level of the TD(lambda) linear value function with accumulating traces.
//
// Channel  Ports                                               Transfer
// -------  --------------------------------------------------  ----------------------
// input    opcode, feature_index_0..7, reward, next_value      start high, busy low
// result   value_sum, td_error                                 done high, one cycle
// config   cfg_write, cfg_addr, cfg_data                       cfg_write high
//
// After rst the block runs a clearing pass that zeroes both tables; busy is high
// during it while configuration writes are taken.
// Each item first reads its active weights one tiling at a time through one read
// port of each table; an update also bumps their traces.
// A query reports done once the gather ends. A clear adds a sweep that zeroes
// the trace table, and an update adds the TD math and a sweep of one table
// entry per cycle.
// The next item is accepted in the cycle after done; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "td_lambda_linear_value_update_assert.svh"
module td_lambda_linear_value_update
  import tdl_pkg::*;
#(
  parameter int WEIGHT_COUNT = DEF_WEIGHT_COUNT,
  parameter int NUM_TILINGS  = DEF_NUM_TILINGS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  output logic                    done,
  input  logic [1:0]              opcode,
  input  logic [FEAT_W-1:0]       feature_index_0,
  input  logic [FEAT_W-1:0]       feature_index_1,
  input  logic [FEAT_W-1:0]       feature_index_2,
  input  logic [FEAT_W-1:0]       feature_index_3,
  input  logic [FEAT_W-1:0]       feature_index_4,
  input  logic [FEAT_W-1:0]       feature_index_5,
  input  logic [FEAT_W-1:0]       feature_index_6,
  input  logic [FEAT_W-1:0]       feature_index_7,
  input  logic signed [VAL_W-1:0] reward,
  input  logic signed [VAL_W-1:0] next_value,
  output logic signed [VAL_W-1:0] value_sum,
  output logic signed [VAL_W-1:0] td_error,
  input  logic                    cfg_write,
  input  logic [CFG_AW-1:0]       cfg_addr,
  input  logic [CFG_DW-1:0]       cfg_data
);

  localparam int AW = $clog2(WEIGHT_COUNT);

  logic [STEP_W-1:0] step_size;
  logic [RATE_W-1:0] discount_rate;
  logic [RATE_W-1:0] trace_decay;
  idx_vec_t          feat_vec;
  ctrl_t             ctrl;
  logic [AW-1:0]     cnt;

  // Tiling 0 sits in the lowest slot of the index vector.
  assign feat_vec = {feature_index_7, feature_index_6, feature_index_5, feature_index_4,
                     feature_index_3, feature_index_2, feature_index_1, feature_index_0};

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size     <= STEP_RESET;
      discount_rate <= DISCOUNT_RESET;
      trace_decay   <= DECAY_RESET;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_STEP_SIZE:     step_size     <= cfg_data[STEP_W-1:0];
        REG_DISCOUNT_RATE: discount_rate <= cfg_data[RATE_W-1:0];
        REG_TRACE_DECAY:   trace_decay   <= cfg_data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer owns the item flow; the datapath holds both tables and
  // shares one multiply unit between the TD math and the update sweep.
  tdl_seq #(
    .WEIGHT_COUNT (WEIGHT_COUNT),
    .NUM_TILINGS  (NUM_TILINGS)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .done   (done),
    .ctrl   (ctrl),
    .cnt    (cnt)
  );

  tdl_dpath #(
    .WEIGHT_COUNT (WEIGHT_COUNT)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .cnt           (cnt),
    .feature_index (feat_vec),
    .reward        (reward),
    .next_value    (next_value),
    .step_size     (step_size),
    .discount_rate (discount_rate),
    .trace_decay   (trace_decay),
    .value_sum     (value_sum),
    .td_error      (td_error)
  );

  // An accepted item keeps the block busy in the following cycle.
  `TDL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // The block returns to idle right after it shows a result.
  `TDL_ASSERT_NEXT(a_done_idle, done, !busy)
  // A result is shown for a single cycle only.
  `TDL_ASSERT_NEXT(a_done_pulse, done, !done)
  // No result appears while the block is idle.
  `TDL_ASSERT_NOW(a_idle_quiet, !busy, !done)

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the TD(lambda) linear value update block.
`timescale 1ns / 1ps
module testbench;
  import tdl_pkg::*;

  localparam int WEIGHTS   = 4096;
  localparam int TILINGS   = 8;
  localparam int HOT_COUNT = 12;

  // An update or the clearing pass after reset holds the block longest; several times
  // that stretch is allowed without any transfer.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 2 * TILINGS + 8;
  localparam int SHOWN_ERRORS   = 10;

  // The package names only the update and clear codes; every other code reads as a query.
  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic signed [VAL_W-1:0] Q16_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q16_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] Q16_ONE = 32'sh0001_0000;

  typedef struct {
    logic [1:0]              opcode;
    idx_vec_t                feat;
    logic signed [VAL_W-1:0] reward;
    logic signed [VAL_W-1:0] next_value;
  } work_item_t;

  typedef struct {
    logic signed [VAL_W-1:0] value_sum;
    logic signed [VAL_W-1:0] td_error;
  } value_result_t;

  // Steps of the stimulus plan: an item to send, a register write, a pause until every
  // result has come back, or a change of how often the sender holds back.
  typedef enum logic [1:0] {
    ACT_ITEM,
    ACT_CONFIG,
    ACT_DRAIN,
    ACT_IDLE
  } plan_kind_t;

  typedef struct {
    plan_kind_t        kind;
    work_item_t        item;
    logic [CFG_AW-1:0] reg_index;
    logic [CFG_DW-1:0] reg_value;
    int                idle_pct;
  } plan_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    start = 1'b0;
  logic                    busy;
  logic                    done;
  logic [1:0]              opcode = OP_QUERY;
  logic [FEAT_W-1:0]       feature_index_0 = '0;
  logic [FEAT_W-1:0]       feature_index_1 = '0;
  logic [FEAT_W-1:0]       feature_index_2 = '0;
  logic [FEAT_W-1:0]       feature_index_3 = '0;
  logic [FEAT_W-1:0]       feature_index_4 = '0;
  logic [FEAT_W-1:0]       feature_index_5 = '0;
  logic [FEAT_W-1:0]       feature_index_6 = '0;
  logic [FEAT_W-1:0]       feature_index_7 = '0;
  logic signed [VAL_W-1:0] reward = '0;
  logic signed [VAL_W-1:0] next_value = '0;
  logic signed [VAL_W-1:0] value_sum;
  logic signed [VAL_W-1:0] td_error;
  logic                    cfg_write = 1'b0;
  logic [CFG_AW-1:0]       cfg_addr = '0;
  logic [CFG_DW-1:0]       cfg_data = '0;

  always #5 clk = ~clk;

  td_lambda_linear_value_update #(
    .WEIGHT_COUNT(WEIGHTS),
    .NUM_TILINGS (TILINGS)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .opcode         (opcode),
    .feature_index_0(feature_index_0),
    .feature_index_1(feature_index_1),
    .feature_index_2(feature_index_2),
    .feature_index_3(feature_index_3),
    .feature_index_4(feature_index_4),
    .feature_index_5(feature_index_5),
    .feature_index_6(feature_index_6),
    .feature_index_7(feature_index_7),
    .reward         (reward),
    .next_value     (next_value),
    .value_sum      (value_sum),
    .td_error       (td_error),
    .cfg_write      (cfg_write),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Value function model: its own weights, traces and registers, advanced once per
  // accepted item and once per register write.
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0]   weight_mirror [WEIGHTS];
  logic [TRACE_W-1:0]        trace_mirror  [WEIGHTS];
  logic [STEP_W-1:0]         step_mirror     = STEP_RESET;
  logic [RATE_W-1:0]         discount_mirror = DISCOUNT_RESET;
  logic [RATE_W-1:0]         decay_mirror    = DECAY_RESET;

  initial begin
    for (int i = 0; i < WEIGHTS; i++) begin
      weight_mirror[i] = '0;
      trace_mirror[i]  = '0;
    end
  end

  function automatic longint clamp_q16(input longint v);
    if (v > longint'(Q16_MAX)) begin
      return longint'(Q16_MAX);
    end else if (v < longint'(Q16_MIN)) begin
      return longint'(Q16_MIN);
    end
    return v;
  endfunction

  // Divide by 2^16 and round to nearest, ties toward plus infinity.
  function automatic longint round_q16(input longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  task automatic learn_from_item(input work_item_t it, output value_result_t res);
    longint            acc;
    longint            sum;
    longint            td;
    longint            disc;
    longint            gain;
    longint            rate;
    longint            nv;
    longint            rw;
    longint            tr_s;
    longint            wt_s;
    longint unsigned   tr_u;
    longint unsigned   shrink;
    longint unsigned   lam;
    logic [FEAT_W-1:0] f;
    acc = 0;
    td  = 0;
    for (int t = 0; t < TILINGS; t++) begin
      f    = it.feat[t];
      wt_s = weight_mirror[f];
      acc  = acc + wt_s;
    end
    sum = clamp_q16(acc);

    if (it.opcode == OP_UPDATE) begin
      // A tiling that repeats an index bumps its trace once more each time.
      for (int t = 0; t < TILINGS; t++) begin
        f    = it.feat[t];
        tr_u = trace_mirror[f];
        tr_u = tr_u + 64'd65536;
        trace_mirror[f] = (tr_u > TRACE_MAX) ? TRACE_MAX : tr_u[TRACE_W-1:0];
      end
      rate = discount_mirror;
      nv   = it.next_value;
      rw   = it.reward;
      disc = round_q16(rate * nv);
      td   = clamp_q16(rw + disc - sum);
      rate = step_mirror;
      gain = round_q16(rate * td);
      for (int i = 0; i < WEIGHTS; i++) begin
        tr_s = trace_mirror[i];
        wt_s = weight_mirror[i];
        weight_mirror[i] = clamp_q16(wt_s + round_q16(gain * tr_s));
      end
      // The decay factor is gamma*lambda in Q2.32, applied with rounding.
      shrink = discount_mirror;
      lam    = decay_mirror;
      shrink = shrink * lam;
      for (int i = 0; i < WEIGHTS; i++) begin
        tr_u = trace_mirror[i];
        tr_u = (tr_u * shrink + 64'd2147483648) >> 32;
        trace_mirror[i] = (tr_u > TRACE_MAX) ? TRACE_MAX : tr_u[TRACE_W-1:0];
      end
    end else if (it.opcode == OP_CLEAR) begin
      for (int i = 0; i < WEIGHTS; i++) begin
        trace_mirror[i] = '0;
      end
    end

    res.value_sum = sum[VAL_W-1:0];
    res.td_error  = td[VAL_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus plan, filled before reset is released.
  // ---------------------------------------------------------------------------
  plan_entry_t plan_q [$];
  logic [FEAT_W-1:0] hot_idx [HOT_COUNT];

  task automatic plan_item(input logic [1:0] op, input idx_vec_t feats,
                           input logic signed [VAL_W-1:0] rw,
                           input logic signed [VAL_W-1:0] nv);
    plan_entry_t e;
    e.kind            = ACT_ITEM;
    e.item.opcode     = op;
    e.item.feat       = feats;
    e.item.reward     = rw;
    e.item.next_value = nv;
    e.reg_index       = '0;
    e.reg_value       = '0;
    e.idle_pct        = 0;
    plan_q.push_back(e);
  endtask

  task automatic plan_control(input plan_kind_t kind, input logic [CFG_AW-1:0] index,
                              input logic [CFG_DW-1:0] value, input int pct);
    plan_entry_t e;
    e.kind            = kind;
    e.item.opcode     = OP_QUERY;
    e.item.feat       = '0;
    e.item.reward     = '0;
    e.item.next_value = '0;
    e.reg_index       = index;
    e.reg_value       = value;
    e.idle_pct        = pct;
    plan_q.push_back(e);
  endtask

  task automatic plan_registers(input logic [CFG_DW-1:0] step,
                                input logic [CFG_DW-1:0] gamma,
                                input logic [CFG_DW-1:0] lambda);
    plan_control(ACT_CONFIG, REG_STEP_SIZE, step, 0);
    plan_control(ACT_CONFIG, REG_DISCOUNT_RATE, gamma, 0);
    plan_control(ACT_CONFIG, REG_TRACE_DECAY, lambda, 0);
  endtask

  function automatic idx_vec_t same_feats(input logic [FEAT_W-1:0] idx);
    idx_vec_t v;
    for (int t = 0; t < MAX_TILINGS; t++) begin
      v[t] = idx;
    end
    return v;
  endfunction

  function automatic idx_vec_t span_feats(input logic [FEAT_W-1:0] base);
    idx_vec_t v;
    for (int t = 0; t < MAX_TILINGS; t++) begin
      v[t] = base + FEAT_W'(t);
    end
    return v;
  endfunction

  // Mostly modest rewards and values so that weights move without pinning at the rails,
  // with full-range and extreme values mixed in.
  function automatic logic signed [VAL_W-1:0] pick_q16();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) begin
      return $signed($urandom_range(8 * 65536)) - 32'sd262144;
    end else if (r < 90) begin
      return $urandom;
    end else if (r < 95) begin
      return Q16_MAX;
    end
    return Q16_MIN;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: walks the plan, raises start for items, performs register writes
  // only while the block is idle, and runs the model on every accepted item.
  // ---------------------------------------------------------------------------
  value_result_t expected_results [$];
  work_item_t    offered_item;
  plan_entry_t   next_step;
  value_result_t predicted;
  logic          launch;
  logic          reg_fire;
  logic          block_quiet;
  int            sender_idle = 0;

  int n_query = 0;
  int n_update = 0;
  int n_clear = 0;
  int n_spare = 0;
  int n_reg_writes = 0;

  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      launch   = start;
      reg_fire = 1'b0;

      if (start && !busy) begin
        learn_from_item(offered_item, predicted);
        expected_results.push_back(predicted);
        launch = 1'b0;
        case (offered_item.opcode)
          OP_QUERY:  n_query++;
          OP_UPDATE: n_update++;
          OP_CLEAR:  n_clear++;
          default:   n_spare++;
        endcase
      end

      // Quiet means no result outstanding and none on the ports this cycle, so the
      // monitor and the driver agree no matter which runs first.
      block_quiet = (expected_results.size() == 0) && !busy && !done;

      if (!launch && plan_q.size() != 0) begin
        next_step = plan_q[0];
        case (next_step.kind)
          ACT_ITEM: begin
            if ($urandom_range(99) >= sender_idle) begin
              offered_item    = next_step.item;
              opcode          <= next_step.item.opcode;
              feature_index_0 <= next_step.item.feat[0];
              feature_index_1 <= next_step.item.feat[1];
              feature_index_2 <= next_step.item.feat[2];
              feature_index_3 <= next_step.item.feat[3];
              feature_index_4 <= next_step.item.feat[4];
              feature_index_5 <= next_step.item.feat[5];
              feature_index_6 <= next_step.item.feat[6];
              feature_index_7 <= next_step.item.feat[7];
              reward          <= next_step.item.reward;
              next_value      <= next_step.item.next_value;
              launch = 1'b1;
              void'(plan_q.pop_front());
            end
          end
          ACT_CONFIG: begin
            if (block_quiet) begin
              reg_fire = 1'b1;
              cfg_addr <= next_step.reg_index;
              cfg_data <= next_step.reg_value;
              case (next_step.reg_index)
                REG_STEP_SIZE:     step_mirror     = next_step.reg_value[STEP_W-1:0];
                REG_DISCOUNT_RATE: discount_mirror = next_step.reg_value;
                REG_TRACE_DECAY:   decay_mirror    = next_step.reg_value;
                default: ;
              endcase
              n_reg_writes++;
              void'(plan_q.pop_front());
            end
          end
          ACT_DRAIN: begin
            if (block_quiet) begin
              void'(plan_q.pop_front());
            end
          end
          default: begin
            sender_idle = next_step.idle_pct;
            void'(plan_q.pop_front());
          end
        endcase
      end

      start     <= launch;
      cfg_write <= reg_fire;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done pulse carries one result, compared with the oldest
  // prediction.
  // ---------------------------------------------------------------------------
  value_result_t oldest;
  int results_seen = 0;
  int mismatches = 0;

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        if (mismatches < SHOWN_ERRORS) begin
          $display("ERROR: result with no item pending: value_sum=%0d td_error=%0d",
                   value_sum, td_error);
        end
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        if (value_sum !== oldest.value_sum || td_error !== oldest.td_error) begin
          if (mismatches < SHOWN_ERRORS) begin
            $display("ERROR: result %0d: value_sum exp %0d got %0d, td_error exp %0d got %0d",
                     results_seen, oldest.value_sum, value_sum, oldest.td_error, td_error);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles with no item taken, no result and no register write.
  // ---------------------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_write) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
    end
    $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed items, then four random phases with different register
  // settings and sender pacing, then the final verdict.
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    idx_vec_t    feats;
    int unsigned r;
    logic [1:0]  op;

    hot_idx[0] = '0;
    hot_idx[HOT_COUNT-1] = '1;
    for (int h = 1; h < HOT_COUNT - 1; h++) begin
      hot_idx[h] = FEAT_W'($urandom_range(WEIGHTS - 1));
    end

    // Directed part. The first items run with the register values left by reset:
    // zero step, unit discount and zero decay.
    plan_control(ACT_IDLE, '0, '0, 0);
    plan_item(OP_QUERY, same_feats('0), '0, '0);
    plan_item(OP_QUERY, same_feats('1), Q16_MIN, Q16_MAX);
    plan_item(OP_SPARE, span_feats(12'd4088), Q16_MAX, Q16_MIN);
    plan_item(OP_UPDATE, span_feats('0), Q16_ONE, -Q16_ONE);
    plan_item(OP_CLEAR, same_feats('1), Q16_ONE, Q16_ONE);

    // Step of 1/16 with gamma and lambda of one: traces persist between updates.
    plan_registers(17'd4096, 17'd65536, 17'd65536);
    plan_item(OP_UPDATE, same_feats(12'd5), Q16_ONE, '0);
    plan_item(OP_QUERY, same_feats(12'd5), '0, '0);
    plan_item(OP_UPDATE, span_feats(12'd5), -2 * Q16_ONE, Q16_ONE);
    feats = {{4{12'd4095}}, {4{12'd0}}};
    plan_item(OP_UPDATE, feats, Q16_MAX, Q16_MAX);
    plan_item(OP_QUERY, feats, '0, '0);
    plan_item(OP_UPDATE, feats, Q16_MIN, Q16_MIN);
    // A clear still reports the sum of the weights at its indices.
    plan_item(OP_CLEAR, same_feats(12'd5), '0, '0);
    plan_item(OP_UPDATE, same_feats(12'd6), Q16_ONE, Q16_ONE);

    // Discount and decay near two, step just under one: traces roughly quadruple per update and saturate,
    // weights and sums run into both rails.
    plan_registers(17'd65535, 17'h1FFFF, 17'h1FFFF);
    for (int k = 0; k < 4; k++) begin
      plan_item(OP_UPDATE, same_feats(12'd7), Q16_MAX, Q16_MAX);
    end
    plan_item(OP_QUERY, same_feats(12'd7), '0, '0);
    plan_item(OP_UPDATE, same_feats(12'd7), Q16_MIN, Q16_MIN);
    plan_item(OP_QUERY, same_feats(12'd7), '0, '0);

    // All registers at zero: td ignores the next value and traces vanish.
    plan_registers('0, '0, '0);
    plan_item(OP_UPDATE, span_feats(12'd1), -Q16_ONE, Q16_MAX);
    plan_item(OP_QUERY, same_feats(12'd7), '0, '0);
    plan_item(OP_CLEAR, span_feats(12'd100), '0, '0);

    // Random phases. Indices mostly come from a small hot set so that queries read
    // trained weights and traces pile up; the rest span the whole table.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: plan_registers(17'd6554, 17'd58982, 17'd52429);
        1: plan_registers(17'd655, 17'd65536, 17'd65536);
        2: plan_registers(17'd65535, 17'h1FFFF, 17'h1FFFF);
        default: plan_registers(CFG_DW'($urandom_range(65535)),
                                CFG_DW'($urandom_range(131071)),
                                CFG_DW'($urandom_range(131071)));
      endcase
      case (phase)
        1:       plan_control(ACT_IDLE, '0, '0, 84);
        3:       plan_control(ACT_IDLE, '0, '0, 37);
        default: plan_control(ACT_IDLE, '0, '0, 0);
      endcase
      for (int n = 0; n < 30; n++) begin
        // Midway through each phase the sender waits for every result.
        if (n == 15) begin
          plan_control(ACT_DRAIN, '0, '0, 0);
        end
        r = $urandom_range(99);
        if (r < 40) begin
          op = OP_QUERY;
        end else if (r < 85) begin
          op = OP_UPDATE;
        end else if (r < 92) begin
          op = OP_CLEAR;
        end else begin
          op = OP_SPARE;
        end
        if ($urandom_range(9) == 0) begin
          feats = same_feats(hot_idx[$urandom_range(HOT_COUNT - 1)]);
        end else begin
          for (int t = 0; t < MAX_TILINGS; t++) begin
            if ($urandom_range(3) != 0) begin
              feats[t] = hot_idx[$urandom_range(HOT_COUNT - 1)];
            end else begin
              feats[t] = FEAT_W'($urandom_range(WEIGHTS - 1));
            end
          end
        end
        plan_item(op, feats, pick_q16(), pick_q16());
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (plan_q.size() != 0 || start || expected_results.size() != 0) begin
      @(posedge clk);
    end
    // Any stray result would show up within a query's latency.
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d queries, %0d updates, %0d trace clears, %0d spare-code items",
             n_query, n_update, n_clear, n_spare);
    $display("and %0d register writes; %0d results checked, %0d mismatches.",
             n_reg_writes, results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/tdl_pkg.sv
sv/tdl_alu.sv
sv/tdl_dpath.sv
sv/tdl_seq.sv
sv/td_lambda_linear_value_update.sv
tb/testbench.sv
